// ===== rtl/fpsa_pkg.sv =====
// Shared types and constants for the free page stack allocator.
// No dependencies; used by free_page_stack_allocator and fpsa_chk.
`timescale 1ns / 1ps
`default_nettype none

package fpsa_pkg;

  localparam int unsigned DEPTH_DEF = 4096;

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_TAKE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_KERNEL_START = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_KERNEL_END   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_STACK_START  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_STACK_END    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_VIRT_OFFSET  = 3'd4;

  localparam logic [31:0] MEM_TYPE_RAM  = 32'd1;
  localparam logic [31:0] LOW_MEM_LIMIT = 32'h0010_0000;
  localparam int unsigned CNT_W         = 13;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] page_addr;
    logic [63:0] region_base;
    logic [63:0] region_len;
    logic [31:0] region_type;
  } in_word_t;

  typedef struct packed {
    logic [31:0]      taken_page;
    logic [CNT_W-1:0] pages_added;
    logic [CNT_W-1:0] free_count;
    logic [1:0]       status;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/free_page_stack_allocator.sv =====
// Free page stack allocator: LIFO of free 4 KiB page numbers with region walker.
// Depends on fpsa_pkg (word types, op/status/register codes).
`timescale 1ns / 1ps
`default_nettype none

// Channel  | ports                                   | handshake
// ---------+-----------------------------------------+---------------------------------
// in       | start, busy, in_word                    | taken when start && !busy
// out      | out_valid, out_word                     | one-cycle strobe, no backpressure
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | write when cfg_valid && cfg_ready
//
// Sequence: free, take on an empty stack and a skipped region give their word in the
// cycle after the start. A take passes through S_TAKE and S_TRD: the single-port page
// store has a registered read. A walked add-region first spends S_SETUP on the
// physical bounds, then in S_WALK one shared page incrementer/compare unit checks one
// page per cycle, the last check ending the walk at the region end, the 4 GiB
// boundary, the page count or a full stack.
// Reset (rst_n low, synchronous) clears depth, registers and sequencer; the page
// store is not cleared, entries are only read after being pushed.
// busy is high while a take or walk is in progress; the receiver cannot stall.

module free_page_stack_allocator #(
  parameter int unsigned DEPTH = fpsa_pkg::DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  fpsa_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output fpsa_pkg::out_word_t           out_word,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [fpsa_pkg::CFG_IW-1:0]    cfg_index,
  input  wire [31:0]                    cfg_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW = $clog2(DEPTH + 1);
  localparam int unsigned RW = 22;  // remaining-page count, saturates at 2^21

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_WALK  = 5'b00100,
    S_TAKE  = 5'b01000,
    S_TRD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] kstart_r, kend_r, sstart_r, send_r, voff_r;

  // stack
  logic [19:0]   mem [DEPTH];
  logic [DW-1:0] depth_r, depth_nxt;
  logic [19:0]   rd_data_r;
  logic          wr_en;
  logic [19:0]   wr_data;

  // walker
  logic [32:0]            addr_r, addr_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [32:0]            end_lo_r, end_lo_nxt;
  logic                   end_lim_r, end_lim_nxt;
  logic [fpsa_pkg::CNT_W-1:0] added_r, added_nxt;
  logic [31:0]            klo_r, khi_r, slo_r, shi_r;

  // result
  logic                out_valid_nxt;
  fpsa_pkg::out_word_t out_word_r, out_word_nxt;
  logic                out_valid_r;

  logic        accept;
  logic        full;
  logic [64:0] end_sum;
  logic [32:0] base_up;
  logic        walk_stop, walk_skip;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign full      = (depth_r == DW'(DEPTH));
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // region end without wrap; base is below 4 GiB whenever this is used
  assign end_sum = {33'd0, in_word.region_base[31:0]} + {1'b0, in_word.region_len};
  assign base_up = ({1'b0, in_word.region_base[31:0]} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;

  // per-page checks of the shared walk unit
  assign walk_stop = (rem_r == '0) || addr_r[32] || (end_lim_r && (addr_r >= end_lo_r));
  assign walk_skip = (addr_r[31:0] <= fpsa_pkg::LOW_MEM_LIMIT)
                  || ((addr_r[31:0] >= klo_r) && (addr_r[31:0] <= khi_r))
                  || ((addr_r[31:0] >= slo_r) && (addr_r[31:0] <= shi_r));

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    end_lo_nxt    = end_lo_r;
    end_lim_nxt   = end_lim_r;
    added_nxt     = added_r;
    wr_en         = 1'b0;
    wr_data       = in_word.page_addr[31:12];
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_word_nxt.taken_page  = '0;
          out_word_nxt.pages_added = '0;
          out_word_nxt.free_count  = fpsa_pkg::CNT_W'(depth_r);
          out_word_nxt.status      = fpsa_pkg::ST_OK;
          case (in_word.op)
            fpsa_pkg::OP_ADD: begin
              if ((in_word.region_type == fpsa_pkg::MEM_TYPE_RAM)
                  && (in_word.region_base[63:32] == 32'd0)) begin
                addr_nxt    = base_up;
                rem_nxt     = (|in_word.region_len[63:33]) ? RW'(22'h20_0000)
                                                            : RW'(in_word.region_len[32:12]);
                end_lo_nxt  = end_sum[32:0];
                end_lim_nxt = !end_sum[64] && (end_sum[63:33] == 31'd0);
                added_nxt   = '0;
                state_nxt   = S_SETUP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            fpsa_pkg::OP_FREE: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_word_nxt.status = fpsa_pkg::ST_FULL;
              end else begin
                wr_en                   = 1'b1;
                depth_nxt               = depth_r + DW'(1);
                out_word_nxt.free_count = fpsa_pkg::CNT_W'(depth_r + DW'(1));
              end
            end
            fpsa_pkg::OP_TAKE: begin
              if (depth_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.status = fpsa_pkg::ST_EMPTY;
              end else begin
                depth_nxt = depth_r - DW'(1);
                state_nxt = S_TAKE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SETUP: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        wr_data = addr_r[31:12];
        if (walk_stop) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.pages_added = added_r;
          out_word_nxt.free_count  = fpsa_pkg::CNT_W'(depth_r);
          state_nxt                = S_IDLE;
        end else if (!walk_skip && full) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.pages_added = added_r;
          out_word_nxt.free_count  = fpsa_pkg::CNT_W'(depth_r);
          out_word_nxt.status      = fpsa_pkg::ST_FULL;
          state_nxt                = S_IDLE;
        end else begin
          if (!walk_skip) begin
            wr_en     = 1'b1;
            depth_nxt = depth_r + DW'(1);
            added_nxt = added_r + fpsa_pkg::CNT_W'(1);
          end
          addr_nxt = addr_r + 33'h0_0000_1000;
          rem_nxt  = rem_r - RW'(1);
        end
      end
      S_TAKE: begin
        // read of the new top entry is in flight
        state_nxt = S_TRD;
      end
      S_TRD: begin
        out_valid_nxt           = 1'b1;
        out_word_nxt.taken_page = {rd_data_r, 12'h000};
        out_word_nxt.free_count = fpsa_pkg::CNT_W'(depth_r);
        state_nxt               = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      kstart_r    <= '0;
      kend_r      <= '0;
      sstart_r    <= '0;
      send_r      <= '0;
      voff_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpsa_pkg::CFG_KERNEL_START: kstart_r <= cfg_data;
          fpsa_pkg::CFG_KERNEL_END:   kend_r   <= cfg_data;
          fpsa_pkg::CFG_STACK_START:  sstart_r <= cfg_data;
          fpsa_pkg::CFG_STACK_END:    send_r   <= cfg_data;
          fpsa_pkg::CFG_VIRT_OFFSET:  voff_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // walker and result payload
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    rem_r      <= rem_nxt;
    end_lo_r   <= end_lo_nxt;
    end_lim_r  <= end_lim_nxt;
    added_r    <= added_nxt;
    out_word_r <= out_word_nxt;
    if (state_r == S_SETUP) begin
      // physical bounds, modulo 2^32
      klo_r <= kstart_r - voff_r;
      khi_r <= kend_r - voff_r;
      slo_r <= sstart_r - voff_r;
      shi_r <= send_r - voff_r;
    end
  end

  // page store: one write port, one registered read at the top index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[depth_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[depth_r[AW-1:0]];
  end

endmodule

`default_nettype wire

// ===== rtl/fpsa_chk.sv =====
// Port-level checks for free_page_stack_allocator, bound onto the top level.
// Depends on fpsa_pkg (out_word_t, status codes).
`timescale 1ns / 1ps
`default_nettype none

module fpsa_chk (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input fpsa_pkg::out_word_t out_word
);

  // every accepted word either answers next cycle or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted word neither answered nor busy");

  // a result word ends the operation
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // one result per operation: a strobe from a busy operation is not repeated
  // unless a new word is taken in the strobe cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(busy) && !(start && !busy)) |=> !out_valid)
    else $error("repeated result strobe");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == fpsa_pkg::ST_OK
                   || out_word.status == fpsa_pkg::ST_EMPTY
                   || out_word.status == fpsa_pkg::ST_FULL))
    else $error("bad status code");

  a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.taken_page[11:0] == 12'h000))
    else $error("taken page not aligned");

endmodule

bind free_page_stack_allocator fpsa_chk u_fpsa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for free_page_stack_allocator: drives add-region, free and take
// words, predicts every reply with a page-stack ledger and compares field by field.
// Depends on fpsa_pkg (word types, op/status/register codes) and the allocator RTL.
`timescale 1ns / 1ps

module tb;
  import fpsa_pkg::*;

  // op 3 has no meaning: the block must leave the stack alone and answer ok
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam longint unsigned FOUR_GIB = 64'h1_0000_0000;
  localparam longint unsigned PAGE_BYTES = 64'h1000;
  // longest legal quiet stretch is one region walk of a few thousand pages
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned PHASE_WORDS = 300;

  // Mirror of the allocator: registers, page store, depth and the replies still owed.
  class free_page_ledger;
    logic [31:0] kernel_start = '0;
    logic [31:0] kernel_end = '0;
    logic [31:0] stack_start = '0;
    logic [31:0] stack_end = '0;
    logic [31:0] virt_offset = '0;
    logic [19:0] page_store [STACK_DEPTH];
    int unsigned depth = 0;
    out_word_t owed_replies[$];
    int unsigned mismatches = 0;

    function void write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_KERNEL_START: kernel_start = val;
        CFG_KERNEL_END:   kernel_end = val;
        CFG_STACK_START:  stack_start = val;
        CFG_STACK_END:    stack_end = val;
        CFG_VIRT_OFFSET:  virt_offset = val;
        default: ;
      endcase
    endfunction

    function bit push_page(logic [31:0] addr);
      if (depth >= STACK_DEPTH) return 1'b0;
      page_store[depth] = addr[31:12];
      depth++;
      return 1'b1;
    endfunction

    // virtual bounds map to physical ones modulo 2^32; both ends inclusive
    function bit in_phys_range(longint unsigned addr, logic [31:0] vlo, logic [31:0] vhi);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = vlo - virt_offset;
      hi = vhi - virt_offset;
      return addr >= lo && addr <= hi;
    endfunction

    function out_word_t predict_reply(in_word_t w);
      out_word_t e;
      longint unsigned addr, stop, count, i;
      bit unbounded;
      int unsigned added;
      e = '0;
      e.status = ST_OK;
      added = 0;
      case (w.op)
        OP_ADD: begin
          if (w.region_type == MEM_TYPE_RAM && w.region_base[63:32] == 32'h0) begin
            addr = (w.region_base + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
            stop = w.region_base + w.region_len;
            unbounded = stop < w.region_base;   // end wrapped past 2^64
            count = w.region_len >> 12;
            for (i = 0; i < count; i++) begin
              if (addr >= FOUR_GIB) break;
              if (!unbounded && addr >= stop) break;
              if (addr > LOW_MEM_LIMIT && !in_phys_range(addr, kernel_start, kernel_end) &&
                  !in_phys_range(addr, stack_start, stack_end)) begin
                if (!push_page(addr[31:0])) begin
                  e.status = ST_FULL;
                  break;
                end
                added++;
              end
              addr += PAGE_BYTES;
            end
          end
        end
        OP_FREE: begin
          if (!push_page(w.page_addr)) e.status = ST_FULL;
        end
        OP_TAKE: begin
          if (depth == 0) begin
            e.status = ST_EMPTY;
          end else begin
            depth--;
            e.taken_page = {page_store[depth], 12'h000};
          end
        end
        default: ;
      endcase
      e.pages_added = CNT_W'(added);
      e.free_count = CNT_W'(depth);
      return e;
    endfunction

    function void note_request(in_word_t w);
      owed_replies.push_back(predict_reply(w));
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (owed_replies.size() == 0) begin
        $error("reply word %h arrived with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = owed_replies.pop_front();
      if (got.taken_page !== want.taken_page) begin
        $error("taken_page: expected %h, got %h", want.taken_page, got.taken_page);
        mismatches++;
      end
      if (got.pages_added !== want.pages_added) begin
        $error("pages_added: expected %0d, got %0d", want.pages_added, got.pages_added);
        mismatches++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  free_page_ledger ledger = new;
  bit steady = 1'b0;   // when set, the sender inserts no random idle gaps

  always #2 clk = ~clk;

  free_page_stack_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Reply strobe: sampled at the edge that closes its cycle, no backpressure possible.
  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.check_reply(out_word);
  end

  // Watchdog: any accepted word, reply or register write resets the quiet count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_word_t request(logic [1:0] op, logic [31:0] page,
                                       logic [63:0] base, logic [63:0] len,
                                       logic [31:0] kind);
    in_word_t w;
    w.op = op;
    w.page_addr = page;
    w.region_base = base;
    w.region_len = len;
    w.region_type = kind;
    return w;
  endfunction

  // Random word. Regions are aimed at the interesting edges: the excluded kernel and
  // stack windows, the 1 MiB floor and the 4 GiB ceiling. Walks stay short except for
  // the rare fill region that can take the stack to full.
  function automatic in_word_t random_request(int unsigned take_pct);
    in_word_t w;
    logic [31:0] anchor;
    int unsigned roll;
    w = '0;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // noise: anything goes, but a RAM region below 4 GiB is demoted so no huge walk
      w = request(2'($urandom), $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom);
      if (w.region_type == MEM_TYPE_RAM && w.region_base[63:32] == 32'h0)
        w.region_type = 32'h0;
      return w;
    end
    roll = $urandom_range(0, 99);
    if (roll < take_pct) return request(OP_TAKE, $urandom, '0, '0, '0);
    if (roll < take_pct + (100 - take_pct) * 2 / 5)
      return request(OP_FREE, $urandom, '0, '0, '0);

    w.op = OP_ADD;
    w.page_addr = $urandom;
    w.region_type = ($urandom_range(0, 9) == 0) ? $urandom : MEM_TYPE_RAM;
    if ($urandom_range(0, 9) == 0) w.region_len = 64'($urandom_range(0, 64)) << 12;
    else w.region_len = 64'($urandom_range(0, 8)) << 12;
    if ($urandom_range(0, 3) == 0) w.region_len[11:0] = 12'($urandom);

    if ($urandom_range(0, 49) == 0) begin
      // fill region clear of the kernel and stack windows, unless every page is excluded
      w.region_type = MEM_TYPE_RAM;
      w.region_base = 64'h0400_0000 + (64'($urandom_range(0, 255)) << 12);
      w.region_len = 64'($urandom_range(1000, 4200)) << 12;
      return w;
    end

    case ($urandom_range(0, 9))
      0, 1: anchor = ledger.kernel_start - ledger.virt_offset - ($urandom_range(0, 8) << 12);
      2, 3: anchor = ledger.stack_start - ledger.virt_offset - ($urandom_range(0, 8) << 12);
      4:    anchor = LOW_MEM_LIMIT - ($urandom_range(0, 6) << 12);
      5, 6: begin
        // just under 4 GiB; a wild length here still ends at the ceiling
        anchor = 32'h0 - ($urandom_range(1, 40) << 12);
        if ($urandom_range(0, 1) == 0) w.region_len = {$urandom, $urandom};
      end
      default: anchor = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) anchor[11:0] = 12'($urandom);
    w.region_base = {32'h0, anchor};
    if ($urandom_range(0, 29) == 0) w.region_base[63:32] = $urandom;
    return w;
  endfunction

  // Send one word: start rises at an edge, the word goes when busy is low at an edge.
  // start is left high so back-to-back words need no second assignment in one step.
  task automatic issue(input in_word_t w);
    if (!steady && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    ledger.note_request(w);
  endtask

  // Hold off until every owed reply is in; the block is idle afterward.
  task automatic settle();
    start <= 1'b0;
    while (ledger.owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_reg(idx, val);
  endtask

  // Only called once settled; valid drops after the last write of the burst.
  task automatic program_regs(input logic [31:0] ks, input logic [31:0] ke,
                              input logic [31:0] ss, input logic [31:0] se,
                              input logic [31:0] off);
    write_reg(CFG_KERNEL_START, ks);
    write_reg(CFG_KERNEL_END, ke);
    write_reg(CFG_STACK_START, ss);
    write_reg(CFG_STACK_END, se);
    write_reg(CFG_VIRT_OFFSET, off);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned p, n;
    logic [31:0] off, kphys, sphys, ks, ke, ss, se;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, registers at reset values (windows collapse to page 0) ---
    issue(request(OP_TAKE, '0, '0, '0, '0));                  // take on empty stack
    issue(request(OP_UNUSED, 32'hFFFF_FFFF, '1, '1, '1));     // unused op
    issue(request(OP_FREE, 32'hFFFF_FFFF, '0, '0, '0));       // top page, low bits dropped
    issue(request(OP_FREE, 32'h0000_0FFF, '0, '0, '0));       // page zero
    issue(request(OP_TAKE, '0, '0, '0, '0));                  // LIFO order
    issue(request(OP_TAKE, '0, '0, '0, '0));
    // skipped regions: wrong type, base above 4 GiB, base exactly at 4 GiB
    issue(request(OP_ADD, '0, 64'h0020_0000, 64'h1_0000, 32'hFFFF_FFFF));
    issue(request(OP_ADD, '0, 64'hFFFF_FFFF_0020_0000, 64'h1_0000, MEM_TYPE_RAM));
    issue(request(OP_ADD, '0, 64'h1_0000_0000, 64'h1_0000, MEM_TYPE_RAM));
    // low memory floor: 1 MiB itself is excluded, the page above is not
    issue(request(OP_ADD, '0, 64'h0, 64'h10_2000, MEM_TYPE_RAM));
    // unaligned base rounds up
    issue(request(OP_ADD, '0, 64'h1FFF_F001, 64'h3000, MEM_TYPE_RAM));
    // shorter than a page: nothing walked
    issue(request(OP_ADD, '0, 64'h0020_0000, 64'h0, MEM_TYPE_RAM));
    issue(request(OP_ADD, '0, 64'h0020_0000, 64'hFFF, MEM_TYPE_RAM));
    // end past 4 GiB (the first one wrapping past 2^64), walk stops at the 4 GiB ceiling
    issue(request(OP_ADD, '0, 64'hFFFF_C000, '1, MEM_TYPE_RAM));
    issue(request(OP_ADD, '0, 64'hFFFF_E800, 64'h4000, MEM_TYPE_RAM));

    // --- directed, kernel and page-stack windows with inclusive bounds ---
    settle();
    program_regs(32'hC020_0000, 32'hC021_0000, 32'hC030_0000, 32'hC030_1000, 32'hC000_0000);
    issue(request(OP_ADD, '0, 64'h001F_E000, 64'h1_4000, MEM_TYPE_RAM));
    issue(request(OP_ADD, '0, 64'h002F_F000, 64'h4000, MEM_TYPE_RAM));

    // --- random phases; growth and drain phases alternate so full and empty both occur ---
    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: ;   // keep the windows above
        1: program_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);   // all excluded
        2: program_regs(32'h0, 32'h0020_0FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: begin
          off = $urandom;
          kphys = 32'h0010_0000 + ($urandom_range(0, 4095) << 12);
          sphys = 32'h0010_0000 + ($urandom_range(0, 4095) << 12);
          ks = kphys + off;
          ss = sphys + off;
          // now and then an inverted window that excludes nothing
          ke = ($urandom_range(0, 7) == 0) ? ks - 32'h1000
                                           : ks + ($urandom_range(0, 40) << 12);
          se = ($urandom_range(0, 7) == 0) ? ss - 32'h1000
                                           : ss + ($urandom_range(0, 40) << 12);
          program_regs(ks, ke, ss, se, off);
        end
      endcase
      steady = (p == 3);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 199) == 0) settle();
        issue(random_request((p % 2 == 0) ? 35 : 80));
      end
    end
    steady = 1'b0;

    // --- closing: from an empty stack one region fills all of it and overflows ---
    while (ledger.depth != 0) issue(request(OP_TAKE, '0, '0, '0, '0));
    issue(request(OP_ADD, '0, 64'h0400_0000, 64'h0110_0000, MEM_TYPE_RAM));
    issue(request(OP_FREE, 32'h1234_5678, '0, '0, '0));       // push onto a full stack
    issue(request(OP_ADD, '0, 64'h0800_0000, 64'h4000, MEM_TYPE_RAM));
    issue(request(OP_TAKE, '0, '0, '0, '0));

    settle();
    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
